@@ rtl/fbsf_pkg.sv @@
// Package for the bit stuffing flag framer.
// Holds the command record passed from front to back, the sequencer states
// and the framing constants. Depends on nothing.
`default_nettype none

package fbsf_pkg;

  localparam int unsigned CNT_W = 13;

  localparam logic [7:0]       FLAG_WORD        = 8'b0111_1110;
  localparam logic [CNT_W-1:0] FRAME_BITS_RESET = 13'd256;
  localparam logic [2:0]       RUN_BEFORE_STUFF = 3'd4;

  localparam logic [1:0] PRE_NONE       = 2'd0;
  localparam logic [1:0] PRE_OPEN       = 2'd1;
  localparam logic [1:0] PRE_CLOSE_OPEN = 2'd2;

  typedef struct packed {
    logic [1:0] pre_flags;
    logic       data_bit;
    logic       stuff;
    logic       close;
  } cmd_t;

  typedef enum logic [2:0] {
    SEQ_IDLE,
    SEQ_PRE,
    SEQ_DATA,
    SEQ_STUFF,
    SEQ_POST
  } seq_t;

endpackage

`default_nettype wire

@@ rtl/fbsf_if.sv @@
// Valid/ready channel interfaces for the bit stuffing flag framer.
// One carries message bits in, the other carries framed line bits out.
// Depends on nothing.
`default_nettype none

interface fbsf_in_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic msg_end;

  modport source (output valid, output data_bit, output msg_end, input ready);
  modport sink   (input valid, input data_bit, input msg_end, output ready);
endinterface

interface fbsf_out_if;
  logic valid;
  logic ready;
  logic line_bit;
  logic run_last;

  modport source (output valid, output line_bit, output run_last, input ready);
  modport sink   (input valid, input line_bit, input run_last, output ready);
endinterface

`default_nettype wire

@@ rtl/fbsf_front.sv @@
// Front part of the framer: accepts message bits, tracks frame and ones run
// state, and turns each bit into a command for the back part.
// Depends on fbsf_pkg and fbsf_in_if.
`default_nettype none

module fbsf_front (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_we,
  input  wire logic [fbsf_pkg::CNT_W-1:0] cfg_data,
  fbsf_in_if.sink                        bit_in,
  input  wire logic                      q_full,
  output logic                           push,
  output fbsf_pkg::cmd_t                 push_cmd
);
  import fbsf_pkg::*;

  logic [CNT_W-1:0] frame_bits;
  logic             in_frame;
  logic [CNT_W-1:0] frame_count;
  logic [2:0]       ones_run;

  logic [CNT_W-1:0] limit;
  logic             open_new;
  logic             frame_full;
  logic             new_frame;
  logic [2:0]       run_base;
  logic [2:0]       run_after;
  logic [CNT_W-1:0] count_after;
  logic             stuff;

  assign bit_in.ready = !q_full;
  assign push         = bit_in.valid && !q_full;

  always_comb begin
    limit       = (frame_bits == '0) ? CNT_W'(1) : frame_bits;
    open_new    = !in_frame;
    frame_full  = in_frame && (frame_count >= limit);
    new_frame   = open_new || frame_full;
    run_base    = new_frame ? 3'd0 : ones_run;
    stuff       = bit_in.data_bit && (run_base == RUN_BEFORE_STUFF);
    run_after   = (bit_in.data_bit && !stuff) ? run_base + 3'd1 : 3'd0;
    count_after = (new_frame ? CNT_W'(0) : frame_count) + CNT_W'(1);

    push_cmd.pre_flags = open_new ? PRE_OPEN : (frame_full ? PRE_CLOSE_OPEN : PRE_NONE);
    push_cmd.data_bit  = bit_in.data_bit;
    push_cmd.stuff     = stuff;
    push_cmd.close     = bit_in.msg_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_bits <= FRAME_BITS_RESET;
    end else if (cfg_we) begin
      frame_bits <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_frame    <= 1'b0;
      frame_count <= '0;
      ones_run    <= '0;
    end else if (push) begin
      if (bit_in.msg_end) begin
        in_frame    <= 1'b0;
        frame_count <= '0;
        ones_run    <= '0;
      end else begin
        in_frame    <= 1'b1;
        frame_count <= count_after;
        ones_run    <= run_after;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/fbsf_queue.sv @@
// Short command queue between the front and back parts of the framer.
// A small register array with read and write pointers and a fill count.
// Depends on fbsf_pkg.
`default_nettype none

module fbsf_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire fbsf_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output fbsf_pkg::cmd_t      head_cmd,
  output logic                full,
  output logic                empty
);
  import fbsf_pkg::*;

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  cmd_t          mem [DEPTH];
  logic [AW-1:0] wr_ptr;
  logic [AW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign head_cmd = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/fbsf_back.sv @@
// Back part of the framer: takes one command at a time from the queue and
// serializes its flags, data bit and stuffed zero onto the line channel.
// Depends on fbsf_pkg and fbsf_out_if.
`default_nettype none

module fbsf_back (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_empty,
  input  wire fbsf_pkg::cmd_t q_head,
  output logic                pop,
  fbsf_out_if.source          line_out
);
  import fbsf_pkg::*;

  seq_t       state;
  seq_t       state_next;
  logic [2:0] bit_idx;
  logic [2:0] bit_idx_next;
  logic       pre_left;
  logic       pre_left_next;
  cmd_t       cmd;
  cmd_t       cmd_next;

  logic fire;
  logic done;
  logic load;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= SEQ_IDLE;
      bit_idx  <= '0;
      pre_left <= 1'b0;
    end else begin
      state    <= state_next;
      bit_idx  <= bit_idx_next;
      pre_left <= pre_left_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd <= cmd_next;
  end

  always_comb begin
    state_next        = state;
    bit_idx_next      = bit_idx;
    pre_left_next     = pre_left;
    cmd_next          = cmd;
    done              = 1'b0;
    line_out.valid    = (state != SEQ_IDLE);
    line_out.line_bit = 1'b0;
    line_out.run_last = 1'b0;
    fire              = line_out.valid && line_out.ready;

    unique case (state)
      SEQ_IDLE: begin
        done = 1'b1;
      end
      SEQ_PRE: begin
        line_out.line_bit = FLAG_WORD[bit_idx];
        if (fire) begin
          bit_idx_next = bit_idx + 3'd1;
          if (bit_idx == 3'd7) begin
            if (pre_left) begin
              pre_left_next = 1'b0;
            end else begin
              state_next = SEQ_DATA;
            end
          end
        end
      end
      SEQ_DATA: begin
        line_out.line_bit = cmd.data_bit;
        line_out.run_last = !cmd.stuff && !cmd.close;
        if (fire) begin
          if (cmd.stuff) begin
            state_next = SEQ_STUFF;
          end else if (cmd.close) begin
            state_next   = SEQ_POST;
            bit_idx_next = '0;
          end else begin
            done = 1'b1;
          end
        end
      end
      SEQ_STUFF: begin
        line_out.line_bit = 1'b0;
        line_out.run_last = !cmd.close;
        if (fire) begin
          if (cmd.close) begin
            state_next   = SEQ_POST;
            bit_idx_next = '0;
          end else begin
            done = 1'b1;
          end
        end
      end
      SEQ_POST: begin
        line_out.line_bit = FLAG_WORD[bit_idx];
        line_out.run_last = (bit_idx == 3'd7);
        if (fire) begin
          bit_idx_next = bit_idx + 3'd1;
          if (bit_idx == 3'd7) begin
            done = 1'b1;
          end
        end
      end
      default: begin
        done = 1'b1;
      end
    endcase

    if (done) begin
      state_next = SEQ_IDLE;
    end

    load = done && !q_empty;
    pop  = load;
    if (load) begin
      cmd_next      = q_head;
      bit_idx_next  = '0;
      pre_left_next = (q_head.pre_flags == PRE_CLOSE_OPEN);
      state_next    = (q_head.pre_flags == PRE_NONE) ? SEQ_DATA : SEQ_PRE;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bit_stuffing_flag_framer.sv @@
// Top level of the bit stuffing flag framer: front part, command queue and
// back part. Depends on fbsf_pkg, fbsf_if, fbsf_front, fbsf_queue, fbsf_back.
//
//   Port      Role  Transaction content
//   bit_in    sink  data_bit, msg_end: one message bit
//   line_out  src   line_bit, run_last: one framed line bit
//   cfg_we    in    frame_bits write from cfg_data
//
// Each message bit produces one to 26 line bits; the back part sends one line
// bit per cycle while line_out is ready, so the rate is set by the number of
// line bits per message bit. A bit without flags or stuffing is one line bit.
// The front part takes a new bit whenever the command queue has room.
// Reset is synchronous and empties the queue; frame_bits returns to 256.
`default_nettype none

module bit_stuffing_flag_framer #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       cfg_we,
  input  wire logic [fbsf_pkg::CNT_W-1:0] cfg_data,
  fbsf_in_if.sink                         bit_in,
  fbsf_out_if.source                      line_out
);
  import fbsf_pkg::*;

  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  cmd_t push_cmd;
  cmd_t head_cmd;

  fbsf_front u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .bit_in   (bit_in),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (push_cmd)
  );

  fbsf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  fbsf_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (head_cmd),
    .pop      (q_pop),
    .line_out (line_out)
  );

endmodule

`default_nettype wire

@@ rtl/fbsf_checker.sv @@
// Port checker for the bit stuffing flag framer and its bind statement.
// Sees only the top level's ports. Depends on bit_stuffing_flag_framer.
`default_nettype none

module fbsf_checker (
  input wire logic clk,
  input wire logic rst,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic out_line_bit,
  input wire logic out_run_last
);

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_line_bit) && $stable(out_run_last))
    else $error("Stalled line bit changed.");

  a_run_continues: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !out_run_last |=> out_valid)
    else $error("Line bits of one message bit were interrupted.");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("Line output valid right after reset.");

  a_reset_ready: assert property (@(posedge clk)
    rst |=> in_ready)
    else $error("Input not ready right after reset.");

endmodule

bind bit_stuffing_flag_framer fbsf_checker u_fbsf_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (bit_in.ready),
  .out_valid    (line_out.valid),
  .out_ready    (line_out.ready),
  .out_line_bit (line_out.line_bit),
  .out_run_last (line_out.run_last)
);

`default_nettype wire

@@ verif/bit_stuffing_flag_framer_test.sv @@
// Testbench for bit_stuffing_flag_framer: message bits in, framed line bits out.
// Predicts flags, stuffed zeros and frame breaks, and checks every line bit in order.
// Depends on fbsf_pkg, fbsf_if and the framer RTL.
`timescale 1ns / 1ps

module bit_stuffing_flag_framer_test;
  import fbsf_pkg::*;

  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic data_bit;
    logic msg_end;
  } msg_item_t;

  typedef struct packed {
    logic line_bit;
    logic run_last;
  } line_exp_t;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_we;
  logic [CNT_W-1:0] cfg_data;

  fbsf_in_if  msg_ch ();
  fbsf_out_if line_ch ();

  bit_stuffing_flag_framer dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .bit_in   (msg_ch),
    .line_out (line_ch)
  );

  msg_item_t        msg_bits_pending[$];
  line_exp_t        line_expect[$];
  logic             line_run[$];
  logic [CNT_W-1:0] frame_bits_m;
  logic             in_frame_m;
  logic [CNT_W-1:0] frame_count_m;
  logic [2:0]       ones_run_m;
  int               idle_pct = 16;
  int               error_count = 0;
  int               quiet_cycles = 0;
  logic             in_fire = 1'b0;
  logic             out_fire = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void add_flag();
    for (int k = 7; k >= 0; k--) line_run = {line_run, FLAG_WORD[k]};
    ones_run_m = '0;
  endfunction

  task automatic frame_message_bit(input logic d, input logic last);
    logic [CNT_W-1:0] lim;
    line_exp_t        e;
    lim = (frame_bits_m == '0) ? CNT_W'(1) : frame_bits_m;
    line_run.delete();
    if (!in_frame_m) begin
      add_flag();
      in_frame_m = 1'b1;
      frame_count_m = '0;
    end else if (frame_count_m >= lim) begin
      add_flag();
      add_flag();
      frame_count_m = '0;
    end
    line_run = {line_run, d};
    if (d) begin
      ones_run_m = ones_run_m + 3'd1;
      if (ones_run_m >= 3'd5) begin
        line_run = {line_run, 1'b0};
        ones_run_m = '0;
      end
    end else begin
      ones_run_m = '0;
    end
    frame_count_m = frame_count_m + CNT_W'(1);
    if (last) begin
      add_flag();
      in_frame_m = 1'b0;
      frame_count_m = '0;
    end
    foreach (line_run[i]) begin
      e.line_bit = line_run[i];
      e.run_last = (i == line_run.size() - 1);
      line_expect = {line_expect, e};
    end
  endtask

  function automatic void add_item(input logic d, input logic last);
    msg_item_t m;
    m.data_bit = d;
    m.msg_end = last;
    msg_bits_pending = {msg_bits_pending, m};
  endfunction

  task automatic queue_random_bits(input int n, input int fb);
    int left;
    int len;
    int p;
    int max_len;
    left = n;
    max_len = (fb == 0 ? 1 : fb) * 3 + 2;
    if (max_len > 40) max_len = 40;
    while (left > 0) begin
      len = $urandom_range(max_len, 1);
      p = $urandom_range(1) ? 50 : 85;
      for (int i = 0; i < len && left > 0; i++) begin
        add_item($urandom_range(99) < p, i == len - 1);
        left--;
      end
    end
  endtask

  task automatic wait_line_idle();
    while (msg_bits_pending.size() != 0 || msg_ch.valid || line_expect.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_frame_bits(input logic [CNT_W-1:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= v;
    @(negedge clk);
    cfg_we <= 1'b0;
    frame_bits_m = v;
  endtask

  always @(negedge clk) begin : drive
    msg_item_t nxt;
    if (rst) begin
      msg_ch.valid <= 1'b0;
    end else if (!msg_ch.valid || in_fire) begin
      if (msg_bits_pending.size() != 0 && $urandom_range(99) >= idle_pct) begin
        nxt = msg_bits_pending.pop_front();
        msg_ch.valid <= 1'b1;
        msg_ch.data_bit <= nxt.data_bit;
        msg_ch.msg_end <= nxt.msg_end;
      end else begin
        msg_ch.valid <= 1'b0;
      end
    end
    line_ch.ready <= !rst && ($urandom_range(99) >= idle_pct);
  end

  always @(posedge clk) begin : watch
    line_exp_t e;
    in_fire = !rst && msg_ch.valid === 1'b1 && msg_ch.ready === 1'b1;
    out_fire = !rst && line_ch.valid === 1'b1 && line_ch.ready === 1'b1;
    if (in_fire) frame_message_bit(msg_ch.data_bit, msg_ch.msg_end);
    if (out_fire) begin
      if (line_expect.size() == 0) begin
        $display("%0t: unexpected line bit %0b, run_last %0b", $time, line_ch.line_bit,
                 line_ch.run_last);
        error_count++;
      end else begin
        e = line_expect.pop_front();
        if (line_ch.line_bit !== e.line_bit) begin
          $display("%0t: line_bit expected %0b, got %0b", $time, e.line_bit, line_ch.line_bit);
          error_count++;
        end
        if (line_ch.run_last !== e.run_last) begin
          $display("%0t: run_last expected %0b, got %0b", $time, e.run_last, line_ch.run_last);
          error_count++;
        end
      end
    end
    if (in_fire || out_fire) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("bit_stuffing_flag_framer_test: errors");
      $finish;
    end
  end

  initial begin : stimulus
    int fb_list[9];
    fb_list = '{1, 0, 8191, 4096, 2, 7, 13, 256, 3};
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_data = '0;
    msg_ch.valid = 1'b0;
    msg_ch.data_bit = 1'b0;
    msg_ch.msg_end = 1'b0;
    line_ch.ready = 1'b0;
    frame_bits_m = FRAME_BITS_RESET;
    in_frame_m = 1'b0;
    frame_count_m = '0;
    ones_run_m = '0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    add_item(1'b1, 1'b1);
    add_item(1'b0, 1'b1);
    repeat (4) add_item(1'b1, 1'b0);
    add_item(1'b1, 1'b1);
    wait_line_idle();

    write_frame_bits(CNT_W'(4));
    repeat (3) add_item(1'b1, 1'b0);
    add_item(1'b1, 1'b1);
    repeat (6) add_item(1'b1, 1'b0);
    add_item(1'b0, 1'b0);
    add_item(1'b1, 1'b1);
    wait_line_idle();

    write_frame_bits(CNT_W'(8191));
    add_item(1'b1, 1'b0);
    add_item(1'b0, 1'b0);
    repeat (3) add_item(1'b1, 1'b0);
    wait_line_idle();
    write_frame_bits(CNT_W'(2));
    add_item(1'b1, 1'b1);
    wait_line_idle();

    foreach (fb_list[i]) begin
      write_frame_bits(CNT_W'(fb_list[i]));
      idle_pct = (fb_list[i] == 4096) ? 0 : 16;
      queue_random_bits(45, fb_list[i]);
      wait_line_idle();
    end

    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("bit_stuffing_flag_framer_test: clean");
    end else begin
      $display("bit_stuffing_flag_framer_test: errors");
    end
    $finish;
  end

endmodule
